FILE: src/assert_macros.svh
// Assertion macros shared by the alarm clock RTL.
// Every macro assumes the using module has clk_i and the active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define ACWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequence that must hold at the clock edge after its trigger.
`define ACWE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/acwe_pkg.sv
// Types, codes, tables and helper functions for the alarm clock with encoder set.
// No dependencies; used by every module of the block.
package acwe_pkg;

  typedef enum logic [1:0] {
    EVT_TICK   = 2'd0,
    EVT_ENC    = 2'd1,
    EVT_BUTTON = 2'd2
  } evt_e;

  typedef enum logic [1:0] {
    VIEW_CLOCK     = 2'd0,
    VIEW_ALARM     = 2'd1,
    VIEW_SET_CLOCK = 2'd2,
    VIEW_SET_ALARM = 2'd3
  } view_e;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_e;

  localparam logic [2:0] BTN_VIEW      = 3'd0;
  localparam logic [2:0] BTN_SET_CLOCK = 3'd4;
  localparam logic [2:0] BTN_SET_ALARM = 3'd5;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_COLON = 8'hFC;
  localparam logic [7:0] ARM_MASK  = 8'hFB;

  // One input event as held in the input register.
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] enc;
    logic [2:0] btn;
  } evt_t;

  // Architectural state of the clock after an event.
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [5:0] al_min;
    logic [4:0] al_hour;
    logic       armed;
    view_e      view;
    logic       sounding;
  } clk_state_t;

  // One result item.
  typedef struct packed {
    logic [7:0] seg_min_ones;
    logic [7:0] seg_min_tens;
    logic [7:0] seg_colon;
    logic [7:0] seg_hour_ones;
    logic [7:0] seg_hour_tens;
    logic [7:0] bargraph;
    logic       alarm_sounding;
    logic [1:0] view_state;
  } disp_t;

  // Quadrature transition table, indexed by {previous A/B, current A/B}.
  function automatic dir_e quad_dir(input logic [3:0] idx);
    dir_e d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = DIR_UP;
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_DOWN;
      default:                  d = DIR_HOLD;
    endcase
    return d;
  endfunction

  // Step a counter up or down by one, wrapping between 0 and top.
  function automatic logic [5:0] step_wrap(input logic [5:0] v, input dir_e d,
                                           input logic [5:0] top);
    logic [5:0] r;
    unique case (d)
      DIR_DOWN: r = (v == 6'd0 || v > top) ? top : v - 6'd1;
      DIR_UP:   r = (v >= top) ? 6'd0 : v + 6'd1;
      default:  r = v;
    endcase
    return r;
  endfunction

  // Split a value below 64 into tens and ones digits.
  function automatic logic [7:0] split_bcd(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] ones;
    priority if (v >= 6'd60) tens = 4'd6;
    else if (v >= 6'd50) tens = 4'd5;
    else if (v >= 6'd40) tens = 4'd4;
    else if (v >= 6'd30) tens = 4'd3;
    else if (v >= 6'd20) tens = 4'd2;
    else if (v >= 6'd10) tens = 4'd1;
    else tens = 4'd0;
    ones = v - 6'({tens, 3'b000} + {tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  // Active-low seven-segment code of one decimal digit.
  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'd0:    c = 8'hC0;
      4'd1:    c = 8'hF9;
      4'd2:    c = 8'hA4;
      4'd3:    c = 8'hB0;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h92;
      4'd6:    c = 8'h82;
      4'd7:    c = 8'hF8;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h98;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bar_code(input view_e v);
    logic [7:0] c;
    unique case (v)
      VIEW_CLOCK:     c = 8'hC0;
      VIEW_ALARM:     c = 8'h01;
      VIEW_SET_CLOCK: c = 8'h83;
      VIEW_SET_ALARM: c = 8'hFF;
      default:        c = 8'hC0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/acwe_time_core.sv
// Timekeeping state and its update for one event per cycle while fire_i is high.
// Depends on acwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acwe_time_core import acwe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  evt_t       evt_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  output clk_state_t state_o
);

  clk_state_t st_q, st_d;
  logic [5:0] al_sec_q;
  logic [3:0] last_enc_q, last_enc_d;
  dir_e       dmin, dhr;

  always_comb begin
    st_d       = st_q;
    last_enc_d = last_enc_q;
    dmin       = quad_dir({last_enc_q[1:0], evt_i.enc[1:0]});
    dhr        = quad_dir({last_enc_q[3:2], evt_i.enc[3:2]});
    if (fire_i) begin
      unique case (evt_e'(evt_i.mode))
        EVT_TICK: begin
          if (st_q.sec >= SEC_LAST) begin
            st_d.sec = 6'd0;
            if (st_q.min >= MIN_LAST) begin
              st_d.min  = 6'd0;
              st_d.hour = (st_q.hour >= HOUR_LAST) ? 5'd0 : st_q.hour + 5'd1;
            end else begin
              st_d.min = st_q.min + 6'd1;
            end
          end else begin
            st_d.sec = st_q.sec + 6'd1;
          end
          // The compare sees the time after rollover.
          if (st_q.armed && st_d.hour == st_q.al_hour && st_d.min == st_q.al_min &&
              st_d.sec == al_sec_q) begin
            st_d.sounding = 1'b1;
          end
          if (!st_q.armed) begin
            st_d.sounding = 1'b0;
          end
        end
        EVT_ENC: begin
          if (evt_i.enc != last_enc_q) begin
            if (st_q.view == VIEW_SET_CLOCK) begin
              st_d.min  = step_wrap(st_q.min, dmin, MIN_LAST);
              st_d.hour = 5'(step_wrap({1'b0, st_q.hour}, dhr, {1'b0, HOUR_LAST}));
            end else if (st_q.view == VIEW_SET_ALARM) begin
              st_d.al_min  = step_wrap(st_q.al_min, dmin, MIN_LAST);
              st_d.al_hour = 5'(step_wrap({1'b0, st_q.al_hour}, dhr, {1'b0, HOUR_LAST}));
            end
            last_enc_d = evt_i.enc;
          end
        end
        EVT_BUTTON: begin
          if (evt_i.btn == BTN_VIEW) begin
            st_d.view = view_e'({1'b0, ~st_q.view[0]});
          end else if (evt_i.btn == BTN_SET_CLOCK) begin
            st_d.view = VIEW_SET_CLOCK;
          end else if (evt_i.btn == BTN_SET_ALARM) begin
            st_d.view  = VIEW_SET_ALARM;
            st_d.armed = ~st_q.armed;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.sec      <= 6'd40;
      st_q.min      <= 6'd55;
      st_q.hour     <= 5'd11;
      st_q.al_min   <= 6'd56;
      st_q.al_hour  <= 5'd11;
      st_q.armed    <= 1'b1;
      st_q.view     <= VIEW_CLOCK;
      st_q.sounding <= 1'b0;
      last_enc_q    <= 4'd0;
      al_sec_q      <= 6'd0;
    end else begin
      st_q       <= st_d;
      last_enc_q <= last_enc_d;
      if (cfg_we_i) begin
        al_sec_q <= cfg_wdata_i;
      end
    end
  end

  assign state_o = st_d;

  `ACWE_ASSERT(a_time_range, st_q.sec <= SEC_LAST && st_q.min <= MIN_LAST && st_q.hour <= HOUR_LAST, "clock time out of range")
  `ACWE_ASSERT(a_alarm_range, st_q.al_min <= MIN_LAST && st_q.al_hour <= HOUR_LAST, "alarm time out of range")
  `ACWE_ASSERT_NEXT(a_disarm_quiet, fire_i && evt_i.mode == EVT_TICK && !st_q.armed, !st_q.sounding, "tone on after tick while disarmed")
  `ACWE_ASSERT_NEXT(a_idle_hold, !fire_i, st_q == $past(st_q), "state changed without an event")

endmodule

FILE: src/acwe_display.sv
// Display formatting: digits, colon, blanking and bargraph from the clock state.
// Depends on acwe_pkg; purely combinational.
module acwe_display import acwe_pkg::*; (
  input  clk_state_t state_i,
  output disp_t      disp_o
);

  logic [5:0] m, h;
  logic [7:0] m_bcd, h_bcd, colon, mask;
  logic       odd, show;

  always_comb begin
    odd  = state_i.sec[0];
    mask = state_i.armed ? ARM_MASK : SEG_BLANK;
    if (state_i.view == VIEW_ALARM || state_i.view == VIEW_SET_ALARM) begin
      m = state_i.al_min;
      h = {1'b0, state_i.al_hour};
    end else begin
      m = state_i.min;
      h = {1'b0, state_i.hour};
    end
    if (state_i.view == VIEW_CLOCK) begin
      colon = (odd ? SEG_COLON : SEG_BLANK) & mask;
    end else begin
      colon = SEG_COLON & mask;
    end
    // Set views blink: blank on even seconds.
    show  = !(state_i.view[1] && !odd);
    m_bcd = split_bcd(m);
    h_bcd = split_bcd(h);

    disp_o.seg_min_ones   = show ? seg_digit(m_bcd[3:0]) : SEG_BLANK;
    disp_o.seg_min_tens   = show ? seg_digit(m_bcd[7:4]) : SEG_BLANK;
    disp_o.seg_colon      = show ? colon : SEG_BLANK;
    disp_o.seg_hour_ones  = show ? seg_digit(h_bcd[3:0]) : SEG_BLANK;
    disp_o.seg_hour_tens  = show ? seg_digit(h_bcd[7:4]) : SEG_BLANK;
    disp_o.bargraph       = bar_code(state_i.view);
    disp_o.alarm_sounding = state_i.sounding;
    disp_o.view_state     = state_i.view;
  end

endmodule

FILE: src/alarm_clock_with_encoder_set.sv
// Top level of the alarm clock with encoder time setting.
// Depends on acwe_pkg, acwe_time_core, acwe_display and assert_macros.svh.
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  ------------------------------------
//   event     in         in_valid_i / in_stall_o  mode_i, encoder_bits_i, button_i
//   result    out        out_valid_o / out_stall_i seven segment bytes, bargraph, flags
//   config    in         cfg_we_i                 cfg_wdata_i (alarm second)
//
// Every event passes from transfer into the input register, then through the state
// update and display logic into the result register. One event can be transferred
// each cycle unless a result stalls; the state update is a single pass.
// Reset is asynchronous and active low; it loads the clock to 11:55:40, armed,
// clock view, and empties both pipeline stages.
// A stalled result holds the result register and, through in_stall_o, the input
// register; a new event is still taken while a result waits if the input is free.
`include "assert_macros.svh"

module alarm_clock_with_encoder_set import acwe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] encoder_bits_i,
  input  logic [2:0] button_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] seg_min_ones_o,
  output logic [7:0] seg_min_tens_o,
  output logic [7:0] seg_colon_o,
  output logic [7:0] seg_hour_ones_o,
  output logic [7:0] seg_hour_tens_o,
  output logic [7:0] bargraph_o,
  output logic       alarm_sounding_o,
  output logic [1:0] view_state_o
);

  logic       in_valid_q, in_valid_d;
  logic       out_valid_q, out_valid_d;
  evt_t       evt_q;
  disp_t      out_q;
  disp_t      disp;
  clk_state_t state_nxt;
  logic       advance, fire, load;

  // The held event may move on when the result register is empty or is being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (load) begin
      evt_q.mode <= mode_i;
      evt_q.enc  <= encoder_bits_i;
      evt_q.btn  <= button_i;
    end
    if (fire) begin
      out_q <= disp;
    end
  end

  acwe_time_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .evt_i       (evt_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .state_o     (state_nxt)
  );

  acwe_display u_disp (
    .state_i (state_nxt),
    .disp_o  (disp)
  );

  assign out_valid_o      = out_valid_q;
  assign seg_min_ones_o   = out_q.seg_min_ones;
  assign seg_min_tens_o   = out_q.seg_min_tens;
  assign seg_colon_o      = out_q.seg_colon;
  assign seg_hour_ones_o  = out_q.seg_hour_ones;
  assign seg_hour_tens_o  = out_q.seg_hour_tens;
  assign bargraph_o       = out_q.bargraph;
  assign alarm_sounding_o = out_q.alarm_sounding;
  assign view_state_o     = out_q.view_state;

  `ACWE_ASSERT_NEXT(a_fire_fills, fire, out_valid_q, "processed event left no result")
  `ACWE_ASSERT_NEXT(a_stall_holds, out_valid_q && out_stall_i,
                    out_valid_q && $stable(out_q), "stalled result changed")
  `ACWE_ASSERT(a_stall_only_full,
               !in_stall_o || (in_valid_q && out_valid_q && out_stall_i),
               "input stalled without cause")

endmodule

FILE: verif/alarm_clock_with_encoder_set_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for alarm_clock_with_encoder_set: event stimulus, cycle-free
// prediction of every display result and a field-by-field compare on the result side.
// Depends on acwe_pkg and the RTL of the block only.
module alarm_clock_with_encoder_set_tb import acwe_pkg::*;;

  // Event kind 3 and the buttons without a function are legal inputs that change nothing.
  localparam logic [1:0] EVT_UNUSED   = 2'd3;
  localparam logic [2:0] BTN_UNUSED_3 = 3'd3;
  localparam logic [2:0] BTN_UNUSED_6 = 3'd6;
  localparam logic [2:0] BTN_UNUSED_7 = 3'd7;

  // Time, alarm time and mode as the clock holds them after each event.
  typedef struct {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [5:0] al_min;
    logic [4:0] al_hour;
    logic       armed;
    view_e      view;
    logic [3:0] last_enc;
    logic       sounding;
  } clock_state_t;

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode_i         = 2'd0;
  logic [3:0] encoder_bits_i = 4'd0;
  logic [2:0] button_i       = 3'd0;
  logic       cfg_we_i       = 1'b0;
  logic [5:0] cfg_wdata_i    = 6'd0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] seg_min_ones_o;
  logic [7:0] seg_min_tens_o;
  logic [7:0] seg_colon_o;
  logic [7:0] seg_hour_ones_o;
  logic [7:0] seg_hour_tens_o;
  logic [7:0] bargraph_o;
  logic       alarm_sounding_o;
  logic [1:0] view_state_o;

  clock_state_t clk_model;        // predicted state of the clock
  logic [5:0]   alarm_sec_reg;    // predicted alarm second register
  disp_t        display_q[$];     // displays still owed by the block, oldest first
  int unsigned  mismatch_count = 0;
  int unsigned  events_sent    = 0;
  bit           idle_en        = 1'b1;  // random gaps and stalls allowed

  alarm_clock_with_encoder_set DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .encoder_bits_i   (encoder_bits_i),
    .button_i         (button_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .seg_min_ones_o   (seg_min_ones_o),
    .seg_min_tens_o   (seg_min_tens_o),
    .seg_colon_o      (seg_colon_o),
    .seg_hour_ones_o  (seg_hour_ones_o),
    .seg_hour_tens_o  (seg_hour_tens_o),
    .bargraph_o       (bargraph_o),
    .alarm_sounding_o (alarm_sounding_o),
    .view_state_o     (view_state_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A quadrature code and its phase index (00, 01, 11, 10 -> 0..3) map onto each
  // other through the same expression, so this converts in both directions.
  function automatic logic [1:0] quad_phase(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // One knob moves up when its phase advances by one, down when it goes back by one.
  // A jump of two phases (both lines changed) is treated as no movement.
  function automatic dir_e knob_turn(input logic [1:0] prev, input logic [1:0] cur);
    logic [1:0] delta;
    delta = quad_phase(cur) - quad_phase(prev);
    if (delta == 2'd1) return DIR_UP;
    if (delta == 2'd3) return DIR_DOWN;
    return DIR_HOLD;
  endfunction

  // One step of a setting counter that wraps between 0 and top.
  function automatic logic [5:0] nudge(input logic [5:0] v, input dir_e d,
                                       input logic [5:0] top);
    if (d == DIR_DOWN) return (v == 6'd0 || v > top) ? top : v - 6'd1;
    if (d == DIR_UP) return (v >= top) ? 6'd0 : v + 6'd1;
    return v;
  endfunction

  function automatic logic [7:0] digit_seg(input int unsigned d);
    case (d)
      0:       return 8'hC0;
      1:       return 8'hF9;
      2:       return 8'hA4;
      3:       return 8'hB0;
      4:       return 8'h99;
      5:       return 8'h92;
      6:       return 8'h82;
      7:       return 8'hF8;
      8:       return 8'h80;
      default: return 8'h98;
    endcase
  endfunction

  // Applies one event to the predicted clock and returns the display that follows it.
  function automatic disp_t apply_event(input logic [1:0] mode, input logic [3:0] enc,
                                        input logic [2:0] btn);
    disp_t      r;
    dir_e       dmin;
    dir_e       dhr;
    logic [5:0] m;
    logic [4:0] h;
    logic [7:0] colon;
    logic       odd;
    logic       lit;
    case (mode)
      EVT_TICK: begin
        if (clk_model.sec >= SEC_LAST) begin
          clk_model.sec = 6'd0;
          if (clk_model.min >= MIN_LAST) begin
            clk_model.min  = 6'd0;
            clk_model.hour = (clk_model.hour >= HOUR_LAST) ? 5'd0 : clk_model.hour + 5'd1;
          end else begin
            clk_model.min = clk_model.min + 6'd1;
          end
        end else begin
          clk_model.sec = clk_model.sec + 6'd1;
        end
        // The alarm compare sees the time after the rollover, so second 0 can match.
        if (clk_model.armed && clk_model.hour == clk_model.al_hour &&
            clk_model.min == clk_model.al_min && clk_model.sec == alarm_sec_reg) begin
          clk_model.sounding = 1'b1;
        end
        if (!clk_model.armed) begin
          clk_model.sounding = 1'b0;
        end
      end
      EVT_ENC: begin
        if (enc != clk_model.last_enc) begin
          dmin = knob_turn(clk_model.last_enc[1:0], enc[1:0]);
          dhr  = knob_turn(clk_model.last_enc[3:2], enc[3:2]);
          if (clk_model.view == VIEW_SET_CLOCK) begin
            clk_model.min  = nudge(clk_model.min, dmin, MIN_LAST);
            clk_model.hour = 5'(nudge({1'b0, clk_model.hour}, dhr, {1'b0, HOUR_LAST}));
          end else if (clk_model.view == VIEW_SET_ALARM) begin
            clk_model.al_min  = nudge(clk_model.al_min, dmin, MIN_LAST);
            clk_model.al_hour = 5'(nudge({1'b0, clk_model.al_hour}, dhr, {1'b0, HOUR_LAST}));
          end
          clk_model.last_enc = enc;
        end
      end
      EVT_BUTTON: begin
        if (btn == BTN_VIEW) begin
          // Toggles clock and alarm view; from a set view it lands on one of the two.
          clk_model.view = view_e'({1'b0, ~clk_model.view[0]});
        end else if (btn == BTN_SET_CLOCK) begin
          clk_model.view = VIEW_SET_CLOCK;
        end else if (btn == BTN_SET_ALARM) begin
          clk_model.view  = VIEW_SET_ALARM;
          clk_model.armed = ~clk_model.armed;
        end
      end
      default: ;
    endcase

    odd = clk_model.sec[0];
    if (clk_model.view == VIEW_ALARM || clk_model.view == VIEW_SET_ALARM) begin
      m = clk_model.al_min;
      h = clk_model.al_hour;
    end else begin
      m = clk_model.min;
      h = clk_model.hour;
    end
    colon = (clk_model.view == VIEW_CLOCK && !odd) ? SEG_BLANK : SEG_COLON;
    if (clk_model.armed) begin
      colon = colon & ARM_MASK;
    end
    // The set views blink: every digit and the colon go dark on even seconds.
    lit = odd || clk_model.view == VIEW_CLOCK || clk_model.view == VIEW_ALARM;
    if (lit) begin
      r.seg_min_ones  = digit_seg(m % 10);
      r.seg_min_tens  = digit_seg(m / 10);
      r.seg_colon     = colon;
      r.seg_hour_ones = digit_seg(h % 10);
      r.seg_hour_tens = digit_seg(h / 10);
    end else begin
      r.seg_min_ones  = SEG_BLANK;
      r.seg_min_tens  = SEG_BLANK;
      r.seg_colon     = SEG_BLANK;
      r.seg_hour_ones = SEG_BLANK;
      r.seg_hour_tens = SEG_BLANK;
    end
    case (clk_model.view)
      VIEW_CLOCK:     r.bargraph = 8'hC0;
      VIEW_ALARM:     r.bargraph = 8'h01;
      VIEW_SET_CLOCK: r.bargraph = 8'h83;
      default:        r.bargraph = 8'hFF;
    endcase
    r.alarm_sounding = clk_model.sounding;
    r.view_state     = clk_model.view;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving, stalling and checking
  // ---------------------------------------------------------------------------

  // Sends one event and records its display once the transfer has happened.
  // Called at a falling edge and returns at a falling edge. Valid stays high from one
  // event to the next unless a random gap is inserted.
  task automatic send_event(input logic [1:0] mode, input logic [3:0] enc,
                            input logic [2:0] btn);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    encoder_bits_i <= enc;
    button_i       <= btn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    display_q.push_back(apply_event(mode, enc, btn));
    events_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender until every owed display has come back, then lets the two
  // pipeline stages settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (display_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // The alarm second is only written while the block is idle.
  task automatic load_alarm_second(input logic [5:0] sec_val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sec_val;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    alarm_sec_reg = sec_val;
  endtask

  // The result side stalls in bursts of random length, with free runs in between.
  initial begin : stall_gen
    forever begin
      @(negedge clk_i);
      out_stall_i <= idle_en && ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Every result transfer is compared with the oldest owed display.
  always @(posedge clk_i) begin : result_check
    disp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (display_q.size() == 0) begin
        report_mismatch("result with nothing owed", 0, 0);
      end else begin
        want = display_q.pop_front();
        if (seg_min_ones_o !== want.seg_min_ones)
          report_mismatch("seg_min_ones", seg_min_ones_o, want.seg_min_ones);
        if (seg_min_tens_o !== want.seg_min_tens)
          report_mismatch("seg_min_tens", seg_min_tens_o, want.seg_min_tens);
        if (seg_colon_o !== want.seg_colon)
          report_mismatch("seg_colon", seg_colon_o, want.seg_colon);
        if (seg_hour_ones_o !== want.seg_hour_ones)
          report_mismatch("seg_hour_ones", seg_hour_ones_o, want.seg_hour_ones);
        if (seg_hour_tens_o !== want.seg_hour_tens)
          report_mismatch("seg_hour_tens", seg_hour_tens_o, want.seg_hour_tens);
        if (bargraph_o !== want.bargraph)
          report_mismatch("bargraph", bargraph_o, want.bargraph);
        if (alarm_sounding_o !== want.alarm_sounding)
          report_mismatch("alarm_sounding", alarm_sounding_o, want.alarm_sounding);
        if (view_state_o !== want.view_state)
          report_mismatch("view_state", view_state_o, want.view_state);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Next code of one knob when it is turned one detent in direction d.
  function automatic logic [1:0] knob_code(input logic [1:0] cur, input dir_e d);
    case (d)
      DIR_UP:   return quad_phase(quad_phase(cur) + 2'd1);
      DIR_DOWN: return quad_phase(quad_phase(cur) - 2'd1);
      default:  return cur;
    endcase
  endfunction

  // Shorter way round a dial of the given span from cur to tgt.
  function automatic dir_e heading(input int cur, input int tgt, input int span);
    int ahead;
    if (cur == tgt) return DIR_HOLD;
    ahead = (tgt - cur + span) % span;
    return (ahead <= span / 2) ? DIR_UP : DIR_DOWN;
  endfunction

  task automatic send_noise();
    logic [1:0] mode;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) mode = EVT_TICK;
    else if (roll < 65) mode = EVT_ENC;
    else if (roll < 90) mode = EVT_BUTTON;
    else mode = EVT_UNUSED;
    send_event(mode, 4'($urandom), 3'($urandom));
  endtask

  // Turns both knobs, one clean detent per event, until the time being set (clock
  // or alarm, by the current set view) reaches the target.
  task automatic dial_to(input int hour_tgt, input int min_tgt);
    int   cur_h;
    int   cur_m;
    dir_e dm;
    dir_e dh;
    repeat (40) begin
      if (clk_model.view == VIEW_SET_ALARM) begin
        cur_h = clk_model.al_hour;
        cur_m = clk_model.al_min;
      end else begin
        cur_h = clk_model.hour;
        cur_m = clk_model.min;
      end
      dm = heading(cur_m, min_tgt, 60);
      dh = heading(cur_h, hour_tgt, 24);
      if (dm == DIR_HOLD && dh == DIR_HOLD) break;
      send_event(EVT_ENC, {knob_code(clk_model.last_enc[3:2], dh),
                           knob_code(clk_model.last_enc[1:0], dm)}, 3'($urandom));
    end
  endtask

  // Random walk of both knobs, entering a set view first half of the time.
  task automatic walk_knobs(input int unsigned steps);
    dir_e dm;
    dir_e dh;
    if ($urandom_range(0, 1) == 1) begin
      send_event(EVT_BUTTON, 4'($urandom),
                 ($urandom_range(0, 1) == 1) ? BTN_SET_CLOCK : BTN_SET_ALARM);
    end
    repeat (steps) begin
      dm = dir_e'($urandom_range(0, 2));
      dh = dir_e'($urandom_range(0, 2));
      send_event(EVT_ENC, {knob_code(clk_model.last_enc[3:2], dh),
                           knob_code(clk_model.last_enc[1:0], dm)}, 3'($urandom));
    end
  endtask

  // Sets the clock just short of the alarm time (or near midnight, or anywhere) and
  // lets it run, so that the alarm fires and the day rolls over now and then.
  task automatic chase_alarm();
    int pick;
    int tgt_min;
    pick = $urandom_range(0, 9);
    if (!clk_model.armed && $urandom_range(0, 3) != 0) begin
      send_event(EVT_BUTTON, 4'($urandom), BTN_SET_ALARM);
    end
    send_event(EVT_BUTTON, 4'($urandom), BTN_SET_CLOCK);
    if (pick < 6) begin
      tgt_min = (int'(clk_model.al_min) + 60 - int'($urandom_range(0, 1))) % 60;
      dial_to(clk_model.al_hour, tgt_min);
    end else if (pick < 8) begin
      dial_to(23, 59);
    end else begin
      dial_to($urandom_range(0, 23), $urandom_range(0, 59));
    end
    // Leave the set view most of the time; staying there keeps the blinking display.
    if ($urandom_range(0, 3) != 0) begin
      send_event(EVT_BUTTON, 4'($urandom), BTN_VIEW);
      if ($urandom_range(0, 1) == 1) send_event(EVT_BUTTON, 4'($urandom), BTN_VIEW);
    end
    repeat ($urandom_range(1, 70)) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      else send_event(EVT_TICK, 4'($urandom), 3'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // An unused event kind must leave the reset state on display untouched.
  task automatic test_reset_view();
    send_event(EVT_UNUSED, 4'hF, BTN_UNUSED_7);
  endtask

  // Pulls the alarm minute back to the current minute and lets the alarm fire at the
  // programmed second, then disarms: the tone must stop only at the next tick.
  task automatic test_alarm_fire();
    load_alarm_second(6'd45);
    send_event(EVT_BUTTON, 4'h0, BTN_SET_ALARM);   // set alarm view, disarmed
    send_event(EVT_BUTTON, 4'h0, BTN_SET_ALARM);   // armed again
    send_event(EVT_ENC, 4'b0010, BTN_VIEW);        // alarm minute down by one
    send_event(EVT_BUTTON, 4'h0, BTN_VIEW);        // back to clock view
    repeat (5) send_event(EVT_TICK, 4'h0, BTN_VIEW);
    send_event(EVT_BUTTON, 4'h0, BTN_SET_ALARM);   // disarm while sounding
    send_event(EVT_TICK, 4'h0, BTN_VIEW);
    send_event(EVT_BUTTON, 4'h0, BTN_SET_ALARM);
    send_event(EVT_BUTTON, 4'h0, BTN_VIEW);
  endtask

  // Knob decoding in set clock view: single steps on the minute knob, both knobs at once,
  // a repeated code, a two-line jump, then knob and dead buttons outside the set views.
  task automatic test_knob_setting();
    send_event(EVT_BUTTON, 4'h0, BTN_SET_CLOCK);
    send_event(EVT_ENC, 4'b0011, BTN_VIEW);
    send_event(EVT_ENC, 4'b0001, BTN_VIEW);
    send_event(EVT_ENC, 4'b0100, BTN_VIEW);
    send_event(EVT_ENC, 4'b1110, BTN_VIEW);
    send_event(EVT_ENC, 4'b1110, BTN_VIEW);
    send_event(EVT_ENC, 4'b0001, BTN_VIEW);
    send_event(EVT_BUTTON, 4'h0, BTN_VIEW);
    send_event(EVT_ENC, 4'hF, BTN_VIEW);
    send_event(EVT_BUTTON, 4'h0, BTN_UNUSED_3);
    send_event(EVT_BUTTON, 4'h0, BTN_UNUSED_6);
  endtask

  // Clean setting and running sequences with random content about a third of the time, the rest noise.
  // The alarm second is reloaded every few hundred events, extremes first.
  task automatic test_random_mix(input int unsigned n_events);
    int unsigned stop_at;
    int unsigned next_cfg;
    int unsigned cfg_turn;
    int          roll;
    logic [5:0]  sec_val;
    stop_at  = events_sent + n_events;
    next_cfg = events_sent + 250;
    cfg_turn = 0;
    while (events_sent < stop_at) begin
      if (events_sent >= next_cfg) begin
        case (cfg_turn)
          0:       sec_val = SEC_LAST;
          1:       sec_val = 6'd63;
          2:       sec_val = 6'd0;
          default: sec_val = 6'($urandom_range(0, 63));
        endcase
        load_alarm_second(sec_val);
        cfg_turn++;
        next_cfg = events_sent + 250;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        chase_alarm();
      end else if (roll < 22) begin
        send_event(EVT_BUTTON, 4'($urandom), BTN_SET_ALARM);
        dial_to($urandom_range(0, 23), $urandom_range(0, 59));
        send_event(EVT_BUTTON, 4'($urandom), BTN_VIEW);
      end else if (roll < 35) begin
        walk_knobs($urandom_range(2, 12));
      end else begin
        send_noise();
      end
    end
  endtask

  // Back-to-back transfers with neither side idling.
  task automatic test_quiet_tail();
    idle_en = 1'b0;
    wait_idle();
    // Give the stall generator time to finish its last burst and drop the stall.
    repeat (12) @(negedge clk_i);
    test_random_mix(150);
  endtask

  initial begin : run
    clk_model.sec      = 6'd40;
    clk_model.min      = 6'd55;
    clk_model.hour     = 5'd11;
    clk_model.al_min   = 6'd56;
    clk_model.al_hour  = 5'd11;
    clk_model.armed    = 1'b1;
    clk_model.view     = VIEW_CLOCK;
    clk_model.last_enc = 4'd0;
    clk_model.sounding = 1'b0;
    alarm_sec_reg      = 6'd0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_view();
    test_alarm_fire();
    test_knob_setting();
    test_random_mix(1100);
    test_quiet_tail();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("alarm_clock_with_encoder_set_tb: done, clean");
    end else begin
      $display("alarm_clock_with_encoder_set_tb: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin : watchdog
    #(20_000_000);
    $display("alarm_clock_with_encoder_set_tb: done, errors");
    $finish;
  end

endmodule
